### design/mah_pkg.sv
// mah_pkg: shared types, constants and lookup functions for the
// magnetometer average / heading block. No dependencies.
`timescale 1ns / 1ps

package mah_pkg;

  // field widths of the stream items
  localparam int AXY_W      = 13;
  localparam int AZ_W       = 15;
  localparam int HEAD_W     = 9;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - (2 * AXY_W + AZ_W + HEAD_W);
  localparam int OUT_USER_W = 2;

  // report rate register
  localparam int              RATE_W     = 4;
  localparam logic [RATE_W-1:0] RATE_RESET = 4'd5;

  // magnetometer report timer
  localparam int MAG_W         = 10;
  localparam int MAG_TIMER_CAP = 1000;

  // cordic datapath: angles in 2^-16 degree, vector with 16 fraction bits
  localparam int ANG_FRAC     = 16;
  localparam int XY_W         = 32;
  localparam int Z_W          = 25;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IDX_W = 4;
  localparam logic signed [Z_W-1:0] Z_NINETY = 25'sd5898240;

  // exact headings for axis and diagonal vectors
  localparam logic signed [HEAD_W-1:0] HEAD_ZERO    = 9'sd0;
  localparam logic signed [HEAD_W-1:0] HEAD_P45     = 9'sd45;
  localparam logic signed [HEAD_W-1:0] HEAD_P90     = 9'sd90;
  localparam logic signed [HEAD_W-1:0] HEAD_P135    = 9'sd135;
  localparam logic signed [HEAD_W-1:0] HEAD_P180    = 9'sd180;
  localparam logic signed [HEAD_W-1:0] HEAD_M45     = -9'sd45;
  localparam logic signed [HEAD_W-1:0] HEAD_M90     = -9'sd90;
  localparam logic signed [HEAD_W-1:0] HEAD_M135    = -9'sd135;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_CLOAD,
    ST_ROT,
    ST_OUT
  } mah_state_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic div_load;
    logic div_step;
    logic cor_load;
    logic cor_step;
    logic out_load;
  } mah_ctrl_t;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [CORDIC_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      4'd0:  v = 25'sd2949120;
      4'd1:  v = 25'sd1740967;
      4'd2:  v = 25'sd919879;
      4'd3:  v = 25'sd466945;
      4'd4:  v = 25'sd234379;
      4'd5:  v = 25'sd117304;
      4'd6:  v = 25'sd58666;
      4'd7:  v = 25'sd29335;
      4'd8:  v = 25'sd14668;
      4'd9:  v = 25'sd7334;
      4'd10: v = 25'sd3667;
      4'd11: v = 25'sd1833;
      4'd12: v = 25'sd917;
      4'd13: v = 25'sd458;
      4'd14: v = 25'sd229;
      4'd15: v = 25'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  // report period in ms for a rate in Hz (integer 1000 / rate)
  function automatic logic [MAG_W-1:0] mag_period(input logic [RATE_W-1:0] rate);
    logic [MAG_W-1:0] p;
    unique case (rate)
      4'd0:  p = 10'd1000;
      4'd1:  p = 10'd1000;
      4'd2:  p = 10'd500;
      4'd3:  p = 10'd333;
      4'd4:  p = 10'd250;
      4'd5:  p = 10'd200;
      4'd6:  p = 10'd166;
      4'd7:  p = 10'd142;
      4'd8:  p = 10'd125;
      4'd9:  p = 10'd111;
      4'd10: p = 10'd100;
      4'd11: p = 10'd90;
      4'd12: p = 10'd83;
      4'd13: p = 10'd76;
      4'd14: p = 10'd71;
      4'd15: p = 10'd66;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

endpackage

### design/mah_hist.sv
// mah_hist: per-axis sample history with running sums.
// Depends on mah_pkg for field widths.
`timescale 1ns / 1ps

module mah_hist import mah_pkg::*; #(
  parameter int DEPTH = 5
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      upd,
  input  logic [IN_DATA_W-1:0]                      in_data,
  output logic signed [AZ_W+$clog2(DEPTH)-1:0]      sum_x,
  output logic signed [AZ_W+$clog2(DEPTH)-1:0]      sum_y,
  output logic signed [AZ_W+$clog2(DEPTH)-1:0]      sum_z
);

  localparam int SXY_W  = AXY_W + $clog2(DEPTH);
  localparam int SZ_W   = AZ_W + $clog2(DEPTH);
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

  logic signed [AXY_W-1:0] hx_r [DEPTH];
  logic signed [AXY_W-1:0] hy_r [DEPTH];
  logic signed [AZ_W-1:0]  hz_r [DEPTH];
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic signed [SXY_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [SZ_W-1:0]  sz_r, sz_nxt;
  logic signed [AXY_W-1:0] new_x, new_y;
  logic signed [AZ_W-1:0]  new_z;

  // masked low bits drop out, so the divide is a plain field select
  assign new_x = $signed({in_data[15:8], in_data[7:3]});
  assign new_y = $signed({in_data[31:24], in_data[23:19]});
  assign new_z = $signed({in_data[47:40], in_data[39:33]});

  // running sums: add the new sample, drop the one it replaces
  always_comb begin
    sx_nxt   = sx_r + SXY_W'(new_x) - SXY_W'(hx_r[slot_r]);
    sy_nxt   = sy_r + SXY_W'(new_y) - SXY_W'(hy_r[slot_r]);
    sz_nxt   = sz_r + SZ_W'(new_z) - SZ_W'(hz_r[slot_r]);
    slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
  end

  // history write and slot advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        hx_r[i] <= '0;
        hy_r[i] <= '0;
        hz_r[i] <= '0;
      end
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
      slot_r <= '0;
    end else if (upd) begin
      hx_r[slot_r] <= new_x;
      hy_r[slot_r] <= new_y;
      hz_r[slot_r] <= new_z;
      sx_r         <= sx_nxt;
      sy_r         <= sy_nxt;
      sz_r         <= sz_nxt;
      slot_r       <= slot_nxt;
    end
  end

  assign sum_x = SZ_W'(sx_r);
  assign sum_y = SZ_W'(sy_r);
  assign sum_z = sz_r;

endmodule

### design/mah_div.sv
// mah_div: divider of a signed sum by the history depth using one reciprocal
// multiply, quotient truncated toward zero. No package dependency.
`timescale 1ns / 1ps

module mah_div #(
  parameter int W     = 18,
  parameter int DEPTH = 5,
  parameter int OUT_W = 15
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    step,
  input  logic signed [W-1:0]     sum,
  output logic signed [OUT_W-1:0] avg
);

  // floor(n / DEPTH) equals (n * MULT) >> SHIFT for every magnitude n below 2^W
  localparam int         SHIFT  = W + $clog2(DEPTH);
  localparam int         PROD_W = 2 * W + 1;
  localparam longint     RECIP  = ((longint'(1) << SHIFT) + longint'(DEPTH) - 1) /
                                  longint'(DEPTH);
  localparam logic [W:0] MULT   = (W + 1)'(RECIP);

  logic [W-1:0]      mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [OUT_W-1:0]  quo, res;

  // capture magnitude and sign, then one multiply step
  always_comb begin
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    prod_nxt = prod_r;
    if (load) begin
      neg_nxt = sum[W-1];
      mag_nxt = sum[W-1] ? $unsigned(-sum) : $unsigned(sum);
    end else if (step) begin
      prod_nxt = PROD_W'(mag_r) * PROD_W'(MULT);
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
  end

  // restore the sign on the magnitude quotient
  assign quo = prod_r[SHIFT +: OUT_W];
  assign res = neg_r ? (~quo + OUT_W'(1)) : quo;
  assign avg = $signed(res);

endmodule

### design/mah_cordic.sv
// mah_cordic: iterative vectoring cordic for atan2(ay, ax) in whole degrees,
// with exact answers on the axes and diagonals. Depends on mah_pkg.
`timescale 1ns / 1ps

module mah_cordic import mah_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     step,
  input  logic signed [AXY_W-1:0]  ax,
  input  logic signed [AXY_W-1:0]  ay,
  output logic signed [HEAD_W-1:0] heading
);

  localparam int EXT_W = XY_W - (AXY_W + 1) - ANG_FRAC;

  logic signed [XY_W-1:0]   x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [Z_W-1:0]    z_r, z_nxt, pre_z;
  logic [CORDIC_IDX_W-1:0]  i_r, i_nxt;
  logic                     spec_r, spec_nxt;
  logic signed [HEAD_W-1:0] spec_val_r, spec_val_nxt;
  logic signed [AXY_W:0]    ax_w, ay_w, pre_x, pre_y;
  logic [Z_W-1:0]           z_mag;
  logic [HEAD_W-1:0]        z_deg, z_head;

  assign ax_w = {ax[AXY_W-1], ax};
  assign ay_w = {ay[AXY_W-1], ay};
  assign dx   = y_r >>> i_r;
  assign dy   = x_r >>> i_r;

  // exact cases and left half plane pre-rotation
  always_comb begin
    spec_nxt     = 1'b1;
    spec_val_nxt = HEAD_ZERO;
    priority if (ay == '0) begin
      spec_val_nxt = ax[AXY_W-1] ? HEAD_P180 : HEAD_ZERO;
    end else if (ax == '0) begin
      spec_val_nxt = ay[AXY_W-1] ? HEAD_M90 : HEAD_P90;
    end else if (ax_w == ay_w) begin
      spec_val_nxt = ax[AXY_W-1] ? HEAD_M135 : HEAD_P45;
    end else if (ax_w == -ay_w) begin
      spec_val_nxt = ax[AXY_W-1] ? HEAD_P135 : HEAD_M45;
    end else begin
      spec_nxt = 1'b0;
    end

    if (ax[AXY_W-1]) begin
      if (!ay[AXY_W-1]) begin
        pre_x = ay_w;
        pre_y = -ax_w;
        pre_z = Z_NINETY;
      end else begin
        pre_x = -ay_w;
        pre_y = ax_w;
        pre_z = -Z_NINETY;
      end
    end else begin
      pre_x = ax_w;
      pre_y = ay_w;
      pre_z = '0;
    end
  end

  // one micro-rotation per step
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    if (load) begin
      x_nxt = {{EXT_W{pre_x[AXY_W]}}, pre_x, {ANG_FRAC{1'b0}}};
      y_nxt = {{EXT_W{pre_y[AXY_W]}}, pre_y, {ANG_FRAC{1'b0}}};
      z_nxt = pre_z;
      i_nxt = '0;
    end else if (step) begin
      if (!y_r[XY_W-1]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_lut(i_r);
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_lut(i_r);
      end
      i_nxt = i_r + CORDIC_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      spec_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      if (load) begin
        spec_r <= spec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (load) begin
      spec_val_r <= spec_val_nxt;
    end
  end

  // angle truncated toward zero to whole degrees
  assign z_mag   = z_r[Z_W-1] ? $unsigned(-z_r) : $unsigned(z_r);
  assign z_deg   = z_mag[Z_W-1:ANG_FRAC];
  assign z_head  = z_r[Z_W-1] ? (~z_deg + HEAD_W'(1)) : z_deg;
  assign heading = spec_r ? spec_val_r : $signed(z_head);

endmodule

### design/mah_ctrl.sv
// mah_ctrl: sequencer that steps the divider and cordic for each item.
// Depends on mah_pkg for the state and strobe types.
`timescale 1ns / 1ps

module mah_ctrl import mah_pkg::*; #(
  parameter int DIV_STEPS = 18
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  output logic      in_ready,
  output mah_ctrl_t ctl
);

  localparam int MAX_STEPS = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

  mah_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state and step counter
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) state_nxt = ST_CLOAD;
      end
      ST_CLOAD: begin
        state_nxt = ST_ROT;
        cnt_nxt   = '0;
      end
      ST_ROT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == ROT_LAST) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath strobes
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready     = 1'b1;
      ST_LOAD:  ctl.div_load = 1'b1;
      ST_DIV:   ctl.div_step = 1'b1;
      ST_CLOAD: ctl.cor_load = 1'b1;
      ST_ROT:   ctl.cor_step = 1'b1;
      ST_OUT:   ctl.out_load = out_free;
      default:  ctl          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### design/magnetometer_average_heading_top.sv
// Takes one raw magnetometer sample item (six register bytes) per tick and returns one item
// with the moving averages of X, Y and Z over the last AVERAGE_DEPTH samples, the heading
// atan2(avg_y, avg_x) in whole degrees, and the magnetometer and yaw report flags. The block
// handles one item at a time: between acceptance and a valid result it loads the running sums,
// does one reciprocal multiply for the three averages and one cordic load, runs 16 cordic
// iterations and fills the output register. The next item is accepted only after that. A
// finished result that cannot enter the output register keeps the block busy until the
// register is free; once loaded, the next item can be taken while the result waits there.
// Depends on mah_pkg, mah_hist, mah_div, mah_cordic and mah_ctrl.
`timescale 1ns / 1ps

module magnetometer_average_heading_top import mah_pkg::*; #(
  parameter int AVERAGE_DEPTH = 5,
  parameter int TICK_MS       = 10,
  parameter int YAW_PERIOD_MS = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mean_x, mean_y, mean_z, heading_degrees, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // mag_report_due, yaw_report_due
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wen,
  input  logic [RATE_W-1:0]     cfg_wdata
);

  localparam int SZ_W      = AZ_W + $clog2(AVERAGE_DEPTH);
  localparam int MAG_SUM_W = $clog2(MAG_TIMER_CAP + TICK_MS + 1);
  localparam int YAW_W     = $clog2(YAW_PERIOD_MS + 1);
  localparam int YAW_SUM_W = $clog2(YAW_PERIOD_MS + TICK_MS + 1);

  mah_ctrl_t               ctl;
  logic                    in_fire, out_free;
  logic signed [SZ_W-1:0]  sum_x, sum_y, sum_z;
  logic signed [AXY_W-1:0] avg_x, avg_y;
  logic signed [AZ_W-1:0]  avg_z;
  logic signed [HEAD_W-1:0] heading;

  logic [RATE_W-1:0]       rate_r;
  logic [MAG_W-1:0]        mag_r, mag_nxt, mag_sat;
  logic [MAG_SUM_W-1:0]    mag_sum;
  logic [YAW_W-1:0]        yaw_r, yaw_nxt, yaw_sat;
  logic [YAW_SUM_W-1:0]    yaw_sum;
  logic                    mag_due, yaw_due;
  logic [OUT_USER_W-1:0]   due_r;

  logic [OUT_DATA_W-1:0]   out_tdata_r;
  logic [OUT_USER_W-1:0]   out_tuser_r;
  logic                    out_tvalid_r;

  assign in_fire  = in_tvalid & in_tready;
  assign out_free = ~out_tvalid_r | out_tready;

  mah_ctrl #(.DIV_STEPS(1)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  mah_hist #(.DEPTH(AVERAGE_DEPTH)) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (in_fire),
    .in_data (in_tdata),
    .sum_x   (sum_x),
    .sum_y   (sum_y),
    .sum_z   (sum_z)
  );

  mah_div #(.W(SZ_W), .DEPTH(AVERAGE_DEPTH), .OUT_W(AXY_W)) u_div_x (
    .clk  (clk),
    .load (ctl.div_load),
    .step (ctl.div_step),
    .sum  (sum_x),
    .avg  (avg_x)
  );

  mah_div #(.W(SZ_W), .DEPTH(AVERAGE_DEPTH), .OUT_W(AXY_W)) u_div_y (
    .clk  (clk),
    .load (ctl.div_load),
    .step (ctl.div_step),
    .sum  (sum_y),
    .avg  (avg_y)
  );

  mah_div #(.W(SZ_W), .DEPTH(AVERAGE_DEPTH), .OUT_W(AZ_W)) u_div_z (
    .clk  (clk),
    .load (ctl.div_load),
    .step (ctl.div_step),
    .sum  (sum_z),
    .avg  (avg_z)
  );

  mah_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (ctl.cor_load),
    .step    (ctl.cor_step),
    .ax      (avg_x),
    .ay      (avg_y),
    .heading (heading)
  );

  // report rate register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_wen) begin
      rate_r <= cfg_wdata;
    end
  end

  // saturating report timers, advanced once per item
  always_comb begin
    mag_sum = MAG_SUM_W'(mag_r) + MAG_SUM_W'(TICK_MS);
    mag_sat = (mag_sum > MAG_SUM_W'(MAG_TIMER_CAP)) ? MAG_W'(MAG_TIMER_CAP)
                                                    : mag_sum[MAG_W-1:0];
    mag_due = (rate_r != '0) && (mag_sat >= mag_period(rate_r));
    mag_nxt = mag_due ? '0 : mag_sat;

    yaw_sum = YAW_SUM_W'(yaw_r) + YAW_SUM_W'(TICK_MS);
    yaw_sat = (yaw_sum > YAW_SUM_W'(YAW_PERIOD_MS)) ? YAW_W'(YAW_PERIOD_MS)
                                                    : yaw_sum[YAW_W-1:0];
    yaw_due = (yaw_sat >= YAW_W'(YAW_PERIOD_MS));
    yaw_nxt = yaw_due ? '0 : yaw_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      yaw_r <= '0;
      due_r <= '0;
    end else if (in_fire) begin
      mag_r <= mag_nxt;
      yaw_r <= yaw_nxt;
      due_r <= {yaw_due, mag_due};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, heading, avg_z, avg_y, avg_x};
      out_tuser_r <= due_r;
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tvalid = out_tvalid_r;

endmodule

### design/mah_checker.sv
// mah_checker: port-level assertions for the magnetometer average block,
// bound to the top level. Depends on mah_pkg and the top level's ports.
`timescale 1ns / 1ps

module mah_checker import mah_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // a result never appears the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // heading stays within a half turn
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[49:41]) >= -9'sd180) &&
                   ($signed(out_tdata[49:41]) <= 9'sd180))
    else $error("heading out of range");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:OUT_DATA_W-OUT_PAD_W] == '0))
    else $error("nonzero pad bits in result");

endmodule

bind magnetometer_average_heading_top mah_checker u_mah_checker (.*);
